// File: design/ppot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppot_pkg: shared types and constants for the parallel printer output engine
// Holds the timer width, status codes, register indexes and the structs that
// carry one request, one result and the configuration between modules.
// ----------------------------------------------------------------------------
package ppot_pkg;

    // timer width of the wait and since-timeout counters
    localparam int TIMER_WIDTH = 26;
    localparam int CFG_WIDTH   = 26;
    localparam int PULSE_WIDTH = 8;
    localparam int CMP_WIDTH   = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

    // register indexes on the configuration port
    localparam logic [1:0] REG_FAIL_WINDOW = 2'd0;
    localparam logic [1:0] REG_BUSY_LIMIT  = 2'd1;
    localparam logic [1:0] REG_PULSE_TICKS = 2'd2;

    // register reset values
    localparam logic [CFG_WIDTH-1:0]   FAIL_WINDOW_RST = CFG_WIDTH'(5000000);
    localparam logic [CFG_WIDTH-1:0]   BUSY_LIMIT_RST  = CFG_WIDTH'(30000000);
    localparam logic [PULSE_WIDTH-1:0] PULSE_TICKS_RST = PULSE_WIDTH'(1);

    // operation codes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // status codes
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_WORK    = 3'd1;
    localparam logic [2:0] ST_SENT    = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_ABORT   = 3'd4;
    localparam logic [2:0] ST_FAST    = 3'd5;
    localparam logic [2:0] ST_IGNORED = 3'd6;

    typedef struct packed {
        logic       operation;
        logic [7:0] char_data;
        logic       busy_line;
        logic       abort_key;
    } t_item;

    typedef struct packed {
        logic [7:0] data_lines;
        logic       strobe_n;
        logic       port_driven;
        logic       printer_ready;
        logic [2:0] status;
    } t_result;

    typedef struct packed {
        logic [CFG_WIDTH-1:0]   fail_window;
        logic [CFG_WIDTH-1:0]   busy_limit;
        logic [PULSE_WIDTH-1:0] pulse_ticks;
    } t_cfg;

endpackage

// File: design/parallel_printer_output_timeout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallel_printer_output_timeout: Centronics-style printer output engine
// Takes tick and print requests with the sampled busy line and ctrl-C flag,
// runs the busy wait, data setup and strobe pulse, and reports one result
// per request.
//
//   channel   direction  handshake          payload
//   input     in         i_valid / o_stall  operation, char_data, busy, abort
//   output    out        o_valid / i_stall  data, strobe, driven, ready, status
//   config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// One request per clock while the output is not stalled; a result is valid once
// its request has passed the input register and the state update into the output register.
// The state update is a single pass of counter compares, so it sets the rate.
// Reset clears the valid flags, the engine state and loads register defaults.
// A stalled output holds its result; the input stalls only while the output
// register is full and stalled and the input register holds a request.
// ----------------------------------------------------------------------------
module parallel_printer_output_timeout import ppot_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_operation,
    input  logic [7:0]           i_char_data,
    input  logic                 i_busy_line,
    input  logic                 i_abort_key,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_data_lines,
    output logic                 o_strobe_n,
    output logic                 o_port_driven,
    output logic                 o_printer_ready,
    output logic [2:0]           o_status,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [CFG_WIDTH-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_result r_res;
    t_result res;
    logic    r_out_valid;
    logic    out_free;
    logic    fire;
    logic    in_acc;

    // pipeline control
    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_acc   = i_valid && !o_stall;

    ppot_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item.operation <= i_operation;
            r_item.char_data <= i_char_data;
            r_item.busy_line <= i_busy_line;
            r_item.abort_key <= i_abort_key;
        end
    end

    ppot_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_data_lines    = r_res.data_lines;
    assign o_strobe_n      = r_res.strobe_n;
    assign o_port_driven   = r_res.port_driven;
    assign o_printer_ready = r_res.printer_ready;
    assign o_status        = r_res.status;

endmodule

// File: design/ppot_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppot_cfg: configuration registers
// Three write-only registers loaded from a plain write port; writes to an
// index beyond the list are dropped.
// ----------------------------------------------------------------------------
module ppot_cfg import ppot_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [CFG_WIDTH-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // register file write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fail_window <= FAIL_WINDOW_RST;
            r_cfg.busy_limit  <= BUSY_LIMIT_RST;
            r_cfg.pulse_ticks <= PULSE_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FAIL_WINDOW: r_cfg.fail_window <= i_cfg_data;
                REG_BUSY_LIMIT:  r_cfg.busy_limit  <= i_cfg_data;
                REG_PULSE_TICKS: r_cfg.pulse_ticks <= i_cfg_data[PULSE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/ppot_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppot_core: printer handshake state and per-request update
// Holds phase, counters, timeout mark and the port lines; for each request
// presented with i_fire it computes the result and commits the new state.
// ----------------------------------------------------------------------------
module ppot_core import ppot_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_WAIT   = 2'd1;
    localparam logic [1:0] PH_SETUP  = 2'd2;
    localparam logic [1:0] PH_STROBE = 2'd3;

    localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

    logic [1:0]             r_phase,   n_phase;
    logic [TIMER_WIDTH-1:0] r_wait,    n_wait;
    logic [TIMER_WIDTH-1:0] r_since,   n_since;
    logic                   r_had_to,  n_had_to;
    logic [7:0]             r_data,    n_data;
    logic                   r_strobe,  n_strobe;
    logic                   r_out_en,  n_out_en;
    logic [2:0]             status;

    logic [TIMER_WIDTH-1:0] wait_inc;
    logic [TIMER_WIDTH-1:0] since_inc;
    logic [CMP_WIDTH-1:0]   wait_inc_x;
    logic [CMP_WIDTH-1:0]   since_x;
    logic [CMP_WIDTH-1:0]   short_x;
    logic [CMP_WIDTH-1:0]   long_x;
    logic [PULSE_WIDTH-1:0] width;
    logic                   short_hit;
    logic                   long_hit;
    logic                   width_hit;
    logic                   long_zero;

    // saturating increments and compares against the registers
    always_comb begin
        wait_inc   = (r_wait  != TMAX) ? r_wait  + 1'b1 : r_wait;
        since_inc  = (r_since != TMAX) ? r_since + 1'b1 : r_since;
        wait_inc_x = CMP_WIDTH'(wait_inc);
        since_x    = CMP_WIDTH'(r_since);
        short_x    = CMP_WIDTH'(i_cfg.fail_window);
        long_x     = CMP_WIDTH'(i_cfg.busy_limit);
        width      = (i_cfg.pulse_ticks == '0) ? PULSE_WIDTH'(1) : i_cfg.pulse_ticks;
        short_hit  = r_had_to && (since_x < short_x);
        long_hit   = wait_inc_x >= long_x;
        long_zero  = i_cfg.busy_limit == '0;
        width_hit  = wait_inc >= TIMER_WIDTH'(width);
    end

    // next state for one request
    always_comb begin
        n_phase  = r_phase;
        n_wait   = r_wait;
        n_since  = r_since;
        n_had_to = r_had_to;
        n_data   = r_data;
        n_strobe = r_strobe;
        n_out_en = r_out_en;
        status   = ST_IDLE;

        if (i_item.operation == OP_REQUEST) begin
            if (r_phase != PH_IDLE) begin
                status = ST_IGNORED;
            end else if (short_hit || long_zero) begin
                // fast fail or zero long timeout: mark and stay idle
                n_had_to = 1'b1;
                n_since  = '0;
                n_wait   = '0;
                status   = short_hit ? ST_FAST : ST_TIMEOUT;
            end else begin
                n_data = i_item.char_data;
                n_wait = '0;
                if (!i_item.busy_line) begin
                    n_out_en = 1'b1;
                    n_strobe = 1'b1;
                    n_phase  = PH_SETUP;
                    status   = ST_WORK;
                end else if (i_item.abort_key) begin
                    n_had_to = 1'b1;
                    n_since  = '0;
                    status   = ST_ABORT;
                end else begin
                    n_phase = PH_WAIT;
                    status  = ST_WORK;
                end
            end
        end else begin
            n_since = since_inc;
            unique case (r_phase)
                PH_WAIT: begin
                    n_wait = wait_inc;
                    status = ST_WORK;
                    if (long_hit || (i_item.busy_line && i_item.abort_key)) begin
                        n_had_to = 1'b1;
                        n_since  = '0;
                        n_phase  = PH_IDLE;
                        n_wait   = '0;
                        status   = long_hit ? ST_TIMEOUT : ST_ABORT;
                    end else if (!i_item.busy_line) begin
                        n_out_en = 1'b1;
                        n_strobe = 1'b1;
                        n_phase  = PH_SETUP;
                        n_wait   = '0;
                    end
                end
                PH_SETUP: begin
                    n_wait = wait_inc;
                    status = ST_WORK;
                    if (width_hit) begin
                        n_strobe = 1'b0;
                        n_phase  = PH_STROBE;
                        n_wait   = '0;
                    end
                end
                PH_STROBE: begin
                    n_wait = wait_inc;
                    status = ST_WORK;
                    if (width_hit) begin
                        n_strobe = 1'b1;
                        n_phase  = PH_IDLE;
                        n_wait   = '0;
                        status   = ST_SENT;
                    end
                end
                default: begin
                    status = ST_IDLE;
                end
            endcase
        end
    end

    // state commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_wait   <= '0;
            r_since  <= '0;
            r_had_to <= 1'b0;
            r_data   <= '0;
            r_strobe <= 1'b1;
            r_out_en <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_wait   <= n_wait;
            r_since  <= n_since;
            r_had_to <= n_had_to;
            r_data   <= n_data;
            r_strobe <= n_strobe;
            r_out_en <= n_out_en;
        end
    end

    // result as seen after this request
    always_comb begin
        o_res.data_lines    = n_out_en ? n_data : 8'h00;
        o_res.strobe_n      = n_strobe;
        o_res.port_driven   = n_out_en;
        o_res.printer_ready = !i_item.busy_line;
        o_res.status        = status;
    end

endmodule

// File: design/ppot_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppot_checker: port-level checks for the printer output engine
// Watches the top-level ports and flags results that the engine cannot
// produce; attached to the top level by the bind below.
// ----------------------------------------------------------------------------
module ppot_checker import ppot_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_data_lines,
    input logic       o_strobe_n,
    input logic       o_port_driven,
    input logic [2:0] o_status
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_data_lines))
        else $error("stalled result changed");

    // data lines stay zero until the port is driven
    a_undriven_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_port_driven |-> o_data_lines == 8'h00 && o_strobe_n)
        else $error("data or strobe active on an undriven port");

    // a finished transfer leaves strobe high on a driven port
    a_sent_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_SENT |-> o_strobe_n && o_port_driven)
        else $error("sent reported with strobe low or port undriven");

    // a fast fail or an abort happens only outside the strobe pulse
    a_ignored_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FAST || o_status == ST_ABORT) |-> o_strobe_n)
        else $error("failure reported with strobe low");

endmodule

bind parallel_printer_output_timeout ppot_checker u_ppot_checker (.*);

// File: tb/printer_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printer_result_checker: result checker for the parallel printer engine
// Watches the request, result and register-write ports of the engine and
// keeps its own model of the engine. Each accepted request gets a predicted
// result. Each accepted result is checked field by field against the oldest
// prediction. Mismatches and the number of results still owed go to the top.
// ----------------------------------------------------------------------------
module printer_result_checker import ppot_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_operation,
    input  logic [7:0]           i_char_data,
    input  logic                 i_busy_line,
    input  logic                 i_abort_key,
    // result channel
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [7:0]           i_data_lines,
    input  logic                 i_strobe_n,
    input  logic                 i_port_driven,
    input  logic                 i_printer_ready,
    input  logic [2:0]           i_status,
    // register writes
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [CFG_WIDTH-1:0] i_cfg_data,
    output int                   o_mismatch_count,
    output int                   o_results_owed
);

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_WAIT,
        ENG_SETUP,
        ENG_STROBE
    } t_engine_phase;

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX      = '1;
    localparam int                     REPORT_LIMIT   = 10;

    // model copy of registers and engine state
    t_cfg                   cfg_regs;
    t_engine_phase          eng_phase;
    logic [TIMER_WIDTH-1:0] wait_cnt;
    logic [TIMER_WIDTH-1:0] since_mark;
    logic                   mark_set;
    logic [7:0]             held_byte;
    logic                   strobe_lvl;
    logic                   port_on;

    t_result expected_results[$];
    int      mismatch_count = 0;

    function automatic logic [TIMER_WIDTH-1:0] bump(input logic [TIMER_WIDTH-1:0] v);
        return (v == TIMER_MAX) ? v : v + 1'b1;
    endfunction

    // timeout, abort and fast fail all restart the timeout mark
    function automatic void set_mark();
        mark_set   = 1'b1;
        since_mark = '0;
        eng_phase  = ENG_IDLE;
        wait_cnt   = '0;
    endfunction

    function automatic void begin_transfer();
        port_on    = 1'b1;
        strobe_lvl = 1'b1;
        eng_phase  = ENG_SETUP;
        wait_cnt   = '0;
    endfunction

    function automatic t_result predict_printer_step(input t_item it);
        t_result    r;
        logic [7:0] pulse_len;
        pulse_len = (cfg_regs.pulse_ticks == '0) ? 8'd1 : cfg_regs.pulse_ticks;
        r.status  = ST_IDLE;
        if (it.operation == OP_REQUEST) begin
            if (eng_phase != ENG_IDLE) begin
                r.status = ST_IGNORED;
            end else if (mark_set && since_mark < cfg_regs.fail_window) begin
                set_mark();
                r.status = ST_FAST;
            end else if (cfg_regs.busy_limit == '0) begin
                set_mark();
                r.status = ST_TIMEOUT;
            end else begin
                held_byte = it.char_data;
                if (!it.busy_line) begin
                    begin_transfer();
                    r.status = ST_WORK;
                end else if (it.abort_key) begin
                    set_mark();
                    r.status = ST_ABORT;
                end else begin
                    eng_phase = ENG_WAIT;
                    wait_cnt  = '0;
                    r.status  = ST_WORK;
                end
            end
        end else begin
            since_mark = bump(since_mark);
            case (eng_phase)
                ENG_WAIT: begin
                    wait_cnt = bump(wait_cnt);
                    // timeout wins over busy low, busy low wins over abort
                    if (wait_cnt >= cfg_regs.busy_limit) begin
                        set_mark();
                        r.status = ST_TIMEOUT;
                    end else if (!it.busy_line) begin
                        begin_transfer();
                        r.status = ST_WORK;
                    end else if (it.abort_key) begin
                        set_mark();
                        r.status = ST_ABORT;
                    end else begin
                        r.status = ST_WORK;
                    end
                end
                ENG_SETUP: begin
                    wait_cnt = bump(wait_cnt);
                    if (wait_cnt >= pulse_len) begin
                        strobe_lvl = 1'b0;
                        eng_phase  = ENG_STROBE;
                        wait_cnt   = '0;
                    end
                    r.status = ST_WORK;
                end
                ENG_STROBE: begin
                    wait_cnt = bump(wait_cnt);
                    if (wait_cnt >= pulse_len) begin
                        strobe_lvl = 1'b1;
                        eng_phase  = ENG_IDLE;
                        wait_cnt   = '0;
                        r.status   = ST_SENT;
                    end else begin
                        r.status = ST_WORK;
                    end
                end
                default: begin
                    r.status = ST_IDLE;
                end
            endcase
        end
        r.data_lines    = port_on ? held_byte : 8'h00;
        r.strobe_n      = strobe_lvl;
        r.port_driven   = port_on;
        r.printer_ready = ~it.busy_line;
        return r;
    endfunction

    task automatic note_mismatch(input t_result want, input t_result got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] result mismatch", $realtime);
            $display("  expected data=%02h strobe_n=%0b driven=%0b ready=%0b status=%0d",
                     want.data_lines, want.strobe_n, want.port_driven,
                     want.printer_ready, want.status);
            $display("  actual   data=%02h strobe_n=%0b driven=%0b ready=%0b status=%0d",
                     got.data_lines, got.strobe_n, got.port_driven,
                     got.printer_ready, got.status);
        end
    endtask

    // sample both channels and the register port on the rising edge
    always @(posedge i_clk) begin
        t_item   req;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg_regs.fail_window = FAIL_WINDOW_RST;
            cfg_regs.busy_limit  = BUSY_LIMIT_RST;
            cfg_regs.pulse_ticks = PULSE_TICKS_RST;
            eng_phase  = ENG_IDLE;
            wait_cnt   = '0;
            since_mark = '0;
            mark_set   = 1'b0;
            held_byte  = '0;
            strobe_lvl = 1'b1;
            port_on    = 1'b0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FAIL_WINDOW: cfg_regs.fail_window = i_cfg_data;
                    REG_BUSY_LIMIT:  cfg_regs.busy_limit  = i_cfg_data;
                    REG_PULSE_TICKS: cfg_regs.pulse_ticks = i_cfg_data[PULSE_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got.data_lines    = i_data_lines;
                got.strobe_n      = i_strobe_n;
                got.port_driven   = i_port_driven;
                got.printer_ready = i_printer_ready;
                got.status        = i_status;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("[%0t] result with no request pending: data=%02h status=%0d",
                                 $realtime, got.data_lines, got.status);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got.data_lines !== want.data_lines || got.strobe_n !== want.strobe_n
                        || got.port_driven !== want.port_driven
                        || got.printer_ready !== want.printer_ready
                        || got.status !== want.status) begin
                        note_mismatch(want, got);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                req.operation = i_operation;
                req.char_data = i_char_data;
                req.busy_line = i_busy_line;
                req.abort_key = i_abort_key;
                expected_results.push_back(predict_printer_step(req));
            end
        end
        o_mismatch_count = mismatch_count;
        o_results_owed   = expected_results.size();
    end

endmodule

// File: tb/parallel_printer_output_timeout_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallel_printer_output_timeout_test: testbench top for the printer engine
// Drives tick and print requests through the engine under several register
// settings: a directed pass over ready, busy, timeout, abort, fast fail and
// ignored requests, then random print jobs with random gaps and stalls.
// Checking is done by printer_result_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module parallel_printer_output_timeout_test;
    import ppot_pkg::*;

    localparam int                   IDLE_PCT       = 21;
    localparam int                   WATCHDOG_LIMIT = 3000;
    localparam int                   DRAIN_CYCLES   = 8;
    localparam int                   RANDOM_ITEMS   = 300;
    localparam int                   QUIET_PHASE    = 2;
    localparam logic [CFG_WIDTH-1:0] CFG_MAX        = '1;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic                 operation = OP_TICK;
    logic [7:0]           char_data = '0;
    logic                 busy_line = 1'b0;
    logic                 abort_key = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           data_lines;
    logic                 strobe_n;
    logic                 port_driven;
    logic                 printer_ready;
    logic [2:0]           status;
    logic                 cfg_we    = 1'b0;
    logic [1:0]           cfg_idx   = REG_FAIL_WINDOW;
    logic [CFG_WIDTH-1:0] cfg_data  = '0;

    logic in_taken   = 1'b0;
    logic quiet      = 1'b0;
    int   stuck_cycles = 0;
    int   mismatches;
    int   results_owed;
    int   items_sent = 0;

    parallel_printer_output_timeout dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_stall         (in_stall),
        .i_operation     (operation),
        .i_char_data     (char_data),
        .i_busy_line     (busy_line),
        .i_abort_key     (abort_key),
        .o_valid         (out_valid),
        .i_stall         (out_stall),
        .o_data_lines    (data_lines),
        .o_strobe_n      (strobe_n),
        .o_port_driven   (port_driven),
        .o_printer_ready (printer_ready),
        .o_status        (status),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    printer_result_checker u_result_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_operation      (operation),
        .i_char_data      (char_data),
        .i_busy_line      (busy_line),
        .i_abort_key      (abort_key),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_data_lines     (data_lines),
        .i_strobe_n       (strobe_n),
        .i_port_driven    (port_driven),
        .i_printer_ready  (printer_ready),
        .i_status         (status),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .o_mismatch_count (mismatches),
        .o_results_owed   (results_owed)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // request handshake seen at the edge, read by the driver at the next fall
    always @(posedge clk) begin
        in_taken <= in_valid && !in_stall;
    end

    // watchdog: any accepted request, result or register write restarts it
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // result side back-pressure
    always @(negedge clk) begin
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // one request, held until accepted; idle cycles go in front of it
    task automatic send_request(input logic op, input logic [7:0] ch,
                                input logic busy, input logic abort_now);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        operation = op;
        char_data = ch;
        busy_line = busy;
        abort_key = abort_now;
        @(negedge clk);
        while (!in_taken) @(negedge clk);
        items_sent++;
    endtask

    task automatic send_tick(input logic busy, input logic abort_now);
        send_request(OP_TICK, 8'($urandom), busy, abort_now);
    endtask

    // wait for every result, then let the pipeline empty
    task automatic settle_engine();
        in_valid = 1'b0;
        while (results_owed != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_WIDTH-1:0] value);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    task automatic apply_setting(input logic [CFG_WIDTH-1:0] short_to,
                                 input logic [CFG_WIDTH-1:0] long_to,
                                 input logic [CFG_WIDTH-1:0] pulse);
        settle_engine();
        write_reg(REG_FAIL_WINDOW, short_to);
        write_reg(REG_BUSY_LIMIT, long_to);
        write_reg(REG_PULSE_TICKS, pulse);
    endtask

    // a print request followed by the ticks that carry it along, plus noise
    task automatic run_print_job(input int max_ticks);
        int n;
        send_request(OP_REQUEST, 8'($urandom), $urandom_range(0, 99) < 60,
                     $urandom_range(0, 99) < 15);
        n = $urandom_range(1, max_ticks);
        repeat (n) send_tick($urandom_range(0, 99) < 65, $urandom_range(0, 99) < 8);
        if ($urandom_range(0, 99) < 15) begin
            send_request(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        int phase_idx;
        int phase_start;
        int random_start;
        int long_to;
        int pulse;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults: quick transfer, ignored request, abort, then fast fail
        send_tick(1'b1, 1'b1);
        send_request(OP_REQUEST, 8'hFF, 1'b0, 1'b0);
        send_request(OP_REQUEST, 8'h00, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_request(OP_REQUEST, 8'h55, 1'b1, 1'b1);
        send_request(OP_REQUEST, 8'hAA, 1'b0, 1'b0);

        // small timeouts: wait to timeout, fast fail window, aborts
        apply_setting(CFG_WIDTH'(3), CFG_WIDTH'(4), CFG_WIDTH'(2));
        repeat (3) send_tick(1'b1, 1'b0);
        send_request(OP_REQUEST, 8'h0F, 1'b1, 1'b0);
        repeat (3) send_tick(1'b1, 1'b0);
        // count reaches the limit together with busy low: timeout wins
        send_tick(1'b0, 1'b0);
        send_request(OP_REQUEST, 8'hF0, 1'b0, 1'b0);
        repeat (3) send_tick(1'b1, 1'b0);
        send_request(OP_REQUEST, 8'h33, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        repeat (3) send_tick(1'b1, 1'b0);
        send_request(OP_REQUEST, 8'hCC, 1'b1, 1'b0);
        // busy low beats abort during the wait
        send_tick(1'b0, 1'b1);
        repeat (4) send_tick(1'b1, 1'b0);

        // widest pulse and longest wait; the next setting cuts the setup short
        apply_setting(CFG_WIDTH'(1), CFG_MAX, CFG_WIDTH'(8'hFF));
        send_request(OP_REQUEST, 8'h81, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_request(OP_REQUEST, 8'h7E, 1'b0, 1'b0);
        repeat (60) send_tick(1'($urandom), 1'($urandom));
        send_request(OP_REQUEST, 8'h18, 1'b0, 1'b1);
        repeat (20) send_tick(1'($urandom), 1'($urandom));

        // longest fast fail window with a one-tick wait limit
        apply_setting(CFG_MAX, CFG_WIDTH'(1), CFG_WIDTH'(1));
        repeat (6) run_print_job(6);

        // random settings with random print jobs
        random_start = items_sent;
        phase_idx    = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            long_to = (phase_idx == 5) ? 0 : $urandom_range(1, 16);
            pulse   = $urandom_range(1, 4);
            apply_setting(CFG_WIDTH'($urandom_range(1, 12)),
                          (long_to == 0) ? CFG_MAX : CFG_WIDTH'(long_to),
                          CFG_WIDTH'(pulse));
            if (long_to == 0) long_to = 24;
            quiet       = (phase_idx == QUIET_PHASE);
            phase_start = items_sent;
            while (items_sent - phase_start < 50) begin
                run_print_job(long_to + 2 * pulse + 4);
            end
            quiet = 1'b0;
            phase_idx++;
        end

        settle_engine();
        if (mismatches == 0 && results_owed == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
